[sv/timestamped_latency_delay_line_assert.svh]
// Assertion macros for the delay line checker.
`ifndef TIMESTAMPED_LATENCY_DELAY_LINE_ASSERT_SVH
`define TIMESTAMPED_LATENCY_DELAY_LINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tldl_pkg.sv]
// Shared constants and types of the timestamped latency delay line.
package tldl_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int COMPONENTS_DEF = 3;

  localparam int TIME_W     = 40;
  localparam int VALUE_W    = 32;
  localparam int DELAY_W    = 24;
  localparam int MAX_COMP   = 3;
  localparam int IN_DATA_W  = TIME_W + MAX_COMP * VALUE_W;
  localparam int OUT_DATA_W = MAX_COMP * VALUE_W;

  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b0;

  typedef struct packed {
    logic time_we;
    logic val_we;
    logic time_re;
    logic val_re;
    logic load_out;
    logic overflow;
  } tldl_cmd_t;

endpackage

[sv/tldl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tldl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/tldl_ctrl.sv]
// Ring sequencer: pointers, fill count, insert and expiry scan over the time store.
module tldl_ctrl #(
  parameter int DEPTH = tldl_pkg::DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic                         out_free,
  input  logic [tldl_pkg::TIME_W-1:0]  now,
  input  logic [tldl_pkg::DELAY_W-1:0] delay,
  input  logic [tldl_pkg::TIME_W-1:0]  time_rdata,
  output logic                         ready,
  output tldl_pkg::tldl_cmd_t          cmd,
  output logic [AW-1:0]                waddr,
  output logic [AW-1:0]                raddr
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_OUT   = 4'b1000
  } tldl_state_t;

  tldl_state_t   state, state_next;
  logic [AW-1:0] oldest, oldest_next;
  logic [AW-1:0] newest, newest_next;
  logic [CW-1:0] fill, fill_next;
  logic          flag, flag_next;
  logic          expired;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == LAST) ? '0 : s + 1'b1;
  endfunction

  // exact 41-bit compare: stored time plus delay strictly below the new time
  assign expired = ({1'b0, time_rdata} + (tldl_pkg::TIME_W + 1)'(delay)) < {1'b0, now};

  always_comb begin
    state_next  = state;
    oldest_next = oldest;
    newest_next = newest;
    fill_next   = fill;
    flag_next   = flag;
    cmd         = '0;
    waddr       = newest;
    raddr       = oldest;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.time_re = 1'b1;
          flag_next   = 1'b0;
          state_next  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // a full ring gives up its oldest entry before the insert
        if (fill == FULL) begin
          flag_next   = !expired;
          oldest_next = slot_inc(oldest);
          fill_next   = fill;
        end else begin
          fill_next = fill + ONE;
        end
        cmd.time_we = 1'b1;
        cmd.val_we  = 1'b1;
        newest_next = slot_inc(newest);
        raddr       = (fill == FULL) ? slot_inc(oldest) : oldest;
        cmd.time_re = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        if (fill > ONE && expired) begin
          oldest_next = slot_inc(oldest);
          fill_next   = fill - ONE;
          raddr       = slot_inc(oldest);
          cmd.time_re = 1'b1;
        end else begin
          cmd.val_re = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.overflow = flag;
  end

  assign ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      oldest <= '0;
      newest <= '0;
      fill   <= '0;
      flag   <= 1'b0;
    end else begin
      state  <= state_next;
      oldest <= oldest_next;
      newest <= newest_next;
      fill   <= fill_next;
      flag   <= flag_next;
    end
  end

endmodule

[sv/timestamped_latency_delay_line.sv]
// Top level of the timestamped latency delay line.
//
// Input beats on s_* carry a timestamp and a Q16.16 reading; each beat is
// appended to a ring of DEPTH entries held in two single-port-read RAMs
// (timestamps and readings). Entries whose time plus delay_ticks lies below
// the new timestamp are then dropped from the oldest end, the newest always
// kept, and the oldest survivor leaves as one beat on m_*.
// A full ring drops its oldest entry first; m_tuser flags when that entry
// had not yet expired.
// Timing: one item at a time. The accepted beat passes through the insert
// state, the scan, which drops expired entries one by one, and the output
// state, which loads the result register; s_tready returns in the same cycle
// as m_tvalid rises. The scan reads one timestamp per cycle from the time RAM.
// A finished result sits in the output register; if the receiver stalls,
// the next item is still taken and worked through, then waits with s_tready
// low until the output register frees.
// Reset empties the ring and clears delay_ticks; no RAM clearing pass is
// needed, as the fill count keeps unwritten entries from being read.
// delay_ticks sits at APB byte address 0; write it only while idle.
module timestamped_latency_delay_line #(
  parameter int DEPTH      = tldl_pkg::DEPTH_DEF,
  parameter int COMPONENTS = tldl_pkg::COMPONENTS_DEF,
  localparam int AW    = $clog2(DEPTH),
  localparam int VAL_W = tldl_pkg::VALUE_W * COMPONENTS
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: sample_time[39:0], value_x[71:40], value_y[103:72], value_z[135:104]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tldl_pkg::IN_DATA_W-1:0]  s_tdata,
  // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tldl_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: overflow[0]
  output logic                            m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tldl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tldl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tldl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [tldl_pkg::DELAY_W-1:0] delay_ticks;
  logic [tldl_pkg::TIME_W-1:0]  now;
  logic [VAL_W-1:0]             vals;
  logic [tldl_pkg::TIME_W-1:0]  time_rdata;
  logic [VAL_W-1:0]             val_rdata;
  logic [tldl_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                         in_fire;
  logic                         out_free;
  tldl_pkg::tldl_cmd_t          cmd;
  logic [AW-1:0]                waddr;
  logic [AW-1:0]                raddr;

  // configuration port: single register, no wait states
  assign pready  = 1'b1;
  assign cfg_idx = paddr[tldl_pkg::CFG_ADDR_W-1:2];
  assign prdata  = (cfg_idx == tldl_pkg::REG_DELAY) ?
                   tldl_pkg::APB_DATA_W'(delay_ticks) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= '0;
    end else if (psel && penable && pwrite && pready && cfg_idx == tldl_pkg::REG_DELAY) begin
      delay_ticks <= pwdata[tldl_pkg::DELAY_W-1:0];
    end
  end

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // hold the accepted beat for the insert cycle and the scan; unused
  // components above COMPONENTS are dropped here
  always_ff @(posedge clk) begin
    if (in_fire) begin
      now  <= s_tdata[tldl_pkg::TIME_W-1:0];
      vals <= s_tdata[tldl_pkg::TIME_W +: VAL_W];
    end
  end

  tldl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .out_free   (out_free),
    .now        (now),
    .delay      (delay_ticks),
    .time_rdata (time_rdata),
    .ready      (s_tready),
    .cmd        (cmd),
    .waddr      (waddr),
    .raddr      (raddr)
  );

  tldl_ram #(
    .WIDTH (tldl_pkg::TIME_W),
    .DEPTH (DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .we    (cmd.time_we),
    .waddr (waddr),
    .wdata (now),
    .re    (cmd.time_re),
    .raddr (raddr),
    .rdata (time_rdata)
  );

  tldl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (cmd.val_we),
    .waddr (waddr),
    .wdata (vals),
    .re    (cmd.val_re),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // output register: advance when free, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // missing components read as zero through the zero extension
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= tldl_pkg::OUT_DATA_W'(val_rdata);
      m_tuser <= cmd.overflow;
    end
  end

endmodule

[sv/tldl_checker.sv]
// Port-level checker for the delay line, bound to the top level.
`include "timestamped_latency_delay_line_assert.svh"

module tldl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tldl_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  // a stalled result beat holds
  `TLDL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // one item in flight: no new beat straight after an accepted one
  `TLDL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input accepted while an item is in flight")

  // a fresh result means the item is finished and the block is idle again
  `TLDL_ASSERT_NOW(a_result_idle, $rose(m_tvalid), s_tready, "result loaded while still busy")

  // a result cannot appear straight after a new item is accepted
  `TLDL_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared too early")

endmodule

bind timestamped_latency_delay_line tldl_checker u_tldl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
